FILE: rtl/ltpl_pkg.sv
package ltpl_pkg;

    localparam int SAMPLE_W = 28;
    localparam int DEPTH    = 256;
    localparam int PTR_W    = 8;
    localparam int LEN_W    = 9;
    localparam int GAIN_W   = 17;
    localparam int RC_W     = 24;
    localparam int SUM_W    = 38;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;

    localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'd65536;
    localparam logic [GAIN_W-1:0] GAIN_FLOOR = 17'd1966;
    localparam logic [LEN_W-1:0]  LEN_MIN    = 9'd32;
    localparam logic [LEN_W-1:0]  LEN_MAX    = 9'd256;

    typedef enum logic [1:0] {
        CFG_ENABLE  = 2'd0,
        CFG_LENGTH  = 2'd1,
        CFG_RELEASE = 2'd2,
        CFG_CEILING = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              enable;
        logic [LEN_W-1:0]  length;
        logic [RC_W-1:0]   release_coeff;
        logic [GAIN_W-1:0] ceiling;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic [SAMPLE_W-1:0]        peak;
    } t_item;

    // Catmull-Rom weights in 1/128 at t = 1/4, 1/2, 3/4
    function automatic logic signed [7:0] cr_weight(input logic [1:0] k, input logic [1:0] j);
        logic signed [7:0] w;
        w = 8'sd0;
        case (k)
            2'd0: begin
                case (j)
                    2'd0: w = -8'sd9;
                    2'd1: w = 8'sd111;
                    2'd2: w = 8'sd29;
                    default: w = -8'sd3;
                endcase
            end
            2'd1: begin
                case (j)
                    2'd0: w = -8'sd8;
                    2'd1: w = 8'sd72;
                    2'd2: w = 8'sd72;
                    default: w = -8'sd8;
                endcase
            end
            default: begin
                case (j)
                    2'd0: w = -8'sd3;
                    2'd1: w = 8'sd29;
                    2'd2: w = 8'sd111;
                    default: w = -8'sd9;
                endcase
            end
        endcase
        return w;
    endfunction

    function automatic logic [SAMPLE_W-1:0] mag_s(input logic signed [SAMPLE_W-1:0] v);
        return v[SAMPLE_W-1] ? SAMPLE_W'(-v) : SAMPLE_W'(v);
    endfunction

    function automatic logic [SAMPLE_W-1:0] max_u(input logic [SAMPLE_W-1:0] a,
                                                  input logic [SAMPLE_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

FILE: rtl/ltpl_front.sv
module ltpl_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_enable,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [ltpl_pkg::SAMPLE_W-1:0] i_left,
    input  logic signed [ltpl_pkg::SAMPLE_W-1:0] i_right,
    output logic                            o_push_valid,
    input  logic                            i_push_ready,
    output ltpl_pkg::t_item                 o_item
);
    import ltpl_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_CALC, F_PUSH} t_fstate;

    t_fstate r_state;
    logic signed [SAMPLE_W-1:0] r_l, r_r;
    logic signed [SAMPLE_W-1:0] r_hl [3];
    logic signed [SAMPLE_W-1:0] r_hr [3];
    logic [SAMPLE_W-1:0] r_peak;
    logic                r_ch;
    logic [1:0]          r_k;

    logic signed [SAMPLE_W-1:0] p [4];
    logic signed [SUM_W-1:0]    s;
    logic [SUM_W-1:0]           ms, mt;
    logic [SAMPLE_W-1:0]        m_sat;
    logic [SAMPLE_W-1:0]        n_start;

    assign o_stall      = (r_state != F_IDLE);
    assign o_push_valid = (r_state == F_PUSH);
    assign o_item       = '{left: r_l, right: r_r, peak: r_peak};

    // one interpolation point per cycle
    always_comb begin
        p[0] = r_ch ? r_hr[0] : r_hl[0];
        p[1] = r_ch ? r_hr[1] : r_hl[1];
        p[2] = r_ch ? r_hr[2] : r_hl[2];
        p[3] = r_ch ? r_r : r_l;
        s = '0;
        for (int j = 0; j < 4; j++) begin
            s = s + SUM_W'(cr_weight(r_k, 2'(j))) * SUM_W'(p[j]);
        end
        ms = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
        mt = ms + SUM_W'(64);
        m_sat = (|mt[SUM_W-1:SAMPLE_W+7]) ? {SAMPLE_W{1'b1}} : mt[SAMPLE_W+6:7];
    end

    always_comb begin
        n_start = max_u(mag_s(i_left), mag_s(i_right));
        if (i_enable) begin
            n_start = max_u(n_start, max_u(mag_s(r_hl[1]), mag_s(r_hl[2])));
            n_start = max_u(n_start, max_u(mag_s(r_hr[1]), mag_s(r_hr[2])));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_ch    <= 1'b0;
            r_k     <= 2'd0;
            r_peak  <= '0;
            r_l     <= '0;
            r_r     <= '0;
            for (int i = 0; i < 3; i++) begin
                r_hl[i] <= '0;
                r_hr[i] <= '0;
            end
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_l     <= i_left;
                        r_r     <= i_right;
                        r_peak  <= n_start;
                        r_ch    <= 1'b0;
                        r_k     <= 2'd0;
                        r_state <= i_enable ? F_CALC : F_PUSH;
                    end
                end
                F_CALC: begin
                    r_peak <= max_u(r_peak, m_sat);
                    if (r_k == 2'd2) begin
                        r_k <= 2'd0;
                        if (r_ch) begin
                            // advance both histories
                            r_hl[0] <= r_hl[1];
                            r_hl[1] <= r_hl[2];
                            r_hl[2] <= r_l;
                            r_hr[0] <= r_hr[1];
                            r_hr[1] <= r_hr[2];
                            r_hr[2] <= r_r;
                            r_state <= F_PUSH;
                        end
                        r_ch <= 1'b1;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                F_PUSH: begin
                    if (i_push_ready) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/ltpl_queue.sv
module ltpl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_push_ready,
    input  ltpl_pkg::t_item i_item,
    output logic            o_pop_valid,
    input  logic            i_pop,
    output ltpl_pkg::t_item o_head
);
    import ltpl_pkg::*;

    t_item            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic              do_push, do_pop;

    assign o_push_ready = (r_cnt != (QPTR_W+1)'(QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_head       = r_mem[r_rp];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            if (do_push && !do_pop) r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

FILE: rtl/ltpl_back.sv
module ltpl_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ltpl_pkg::t_cfg                       i_cfg,
    input  logic                                 i_q_valid,
    output logic                                 o_q_pop,
    input  ltpl_pkg::t_item                      i_q_item,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [ltpl_pkg::SAMPLE_W-1:0] o_left,
    output logic signed [ltpl_pkg::SAMPLE_W-1:0] o_right,
    output logic [ltpl_pkg::GAIN_W-1:0]          o_gain
);
    import ltpl_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE, B_READ, B_WRITE, B_SCAN, B_DIV, B_GAIN, B_SCALE
    } t_bstate;

    t_bstate r_state;
    t_item   r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    t_item   r_rd;
    logic    r_rd_vld;
    t_item   r_new;
    logic [PTR_W-1:0] r_ptr;
    logic [LEN_W-1:0] r_idx;
    logic             r_pend;
    logic signed [SAMPLE_W-1:0] r_dl, r_dr;
    logic [SAMPLE_W-1:0] r_future;
    logic [SAMPLE_W-1:0] r_rem;
    logic [GAIN_W-1:0]   r_req, r_gain;
    logic [4:0]          r_cnt;
    logic                r_ovalid;
    logic signed [SAMPLE_W-1:0] r_ol, r_or;
    logic [GAIN_W-1:0]   r_og;

    logic [PTR_W-1:0]  raddr;
    logic              we;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  ptr_inc;
    logic [SAMPLE_W-1:0] rd_peak;
    logic [SAMPLE_W:0]   trial;
    logic [GAIN_W-1:0]   diff;
    logic [GAIN_W+RC_W-1:0] prod;
    logic [GAIN_W+RC_W-1:0] prod_r;
    logic [GAIN_W:0]     g_next;
    logic [SAMPLE_W+GAIN_W-1:0] sl, sr;
    logic [SAMPLE_W-1:0] ml, mr;
    logic                out_free;

    assign out_free = !r_ovalid || !i_stall;
    assign o_q_pop  = (r_state == B_IDLE) && i_q_valid && !r_ovalid;
    assign o_valid  = r_ovalid;
    assign o_left   = r_ol;
    assign o_right  = r_or;
    assign o_gain   = r_og;
    assign we       = (r_state == B_WRITE);
    assign raddr    = (r_state == B_SCAN) ? r_idx[PTR_W-1:0] : r_ptr;
    assign rd_peak  = r_rd_vld ? r_rd.peak : '0;
    assign ptr_inc  = LEN_W'(r_ptr) + LEN_W'(1);
    assign trial    = {r_rem, 1'b0};

    always_comb begin
        len = i_cfg.length;
        if (len < LEN_MIN) len = LEN_MIN;
        if (len > LEN_MAX) len = LEN_MAX;
    end

    always_comb begin
        diff   = GAIN_ONE - r_gain;
        prod   = (GAIN_W+RC_W)'(diff) * (GAIN_W+RC_W)'(i_cfg.release_coeff);
        prod_r = prod + (GAIN_W+RC_W)'(24'hFFFFFF);
        if (r_req < r_gain) g_next = {1'b0, r_req};
        else g_next = {1'b0, r_gain} + (GAIN_W+1)'(prod_r[GAIN_W+RC_W-1:RC_W]);
        if (g_next < (GAIN_W+1)'(GAIN_FLOOR)) g_next = (GAIN_W+1)'(GAIN_FLOOR);
        if (g_next > (GAIN_W+1)'(GAIN_ONE))   g_next = (GAIN_W+1)'(GAIN_ONE);
    end

    always_comb begin
        sl = (SAMPLE_W+GAIN_W)'(mag_s(r_dl)) * (SAMPLE_W+GAIN_W)'(r_gain)
           + (SAMPLE_W+GAIN_W)'(32768);
        sr = (SAMPLE_W+GAIN_W)'(mag_s(r_dr)) * (SAMPLE_W+GAIN_W)'(r_gain)
           + (SAMPLE_W+GAIN_W)'(32768);
        ml = sl[SAMPLE_W+15:16];
        mr = sr[SAMPLE_W+15:16];
    end

    // ring memory, registered read
    always_ff @(posedge i_clk) begin
        if (we) r_mem[r_ptr] <= r_new;
        r_rd <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_ptr    <= '0;
            r_gain   <= GAIN_ONE;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            r_pend   <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[raddr];
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (o_q_pop) begin
                        r_new   <= i_q_item;
                        r_state <= B_READ;
                    end
                end
                B_READ: r_state <= B_WRITE;
                B_WRITE: begin
                    r_dl <= r_rd_vld ? r_rd.left  : '0;
                    r_dr <= r_rd_vld ? r_rd.right : '0;
                    r_future <= rd_peak;
                    r_vld[r_ptr] <= 1'b1;
                    r_ptr <= (ptr_inc >= len) ? '0 : ptr_inc[PTR_W-1:0];
                    r_idx  <= '0;
                    r_pend <= 1'b0;
                    if (!i_cfg.enable) begin
                        // pass the delayed pair untouched
                        r_gain   <= GAIN_ONE;
                        r_ol     <= r_rd_vld ? r_rd.left  : '0;
                        r_or     <= r_rd_vld ? r_rd.right : '0;
                        r_og     <= GAIN_ONE;
                        r_ovalid <= 1'b1;
                        r_state  <= B_IDLE;
                    end else begin
                        r_state <= B_SCAN;
                    end
                end
                B_SCAN: begin
                    if (r_pend) r_future <= max_u(r_future, rd_peak);
                    if (r_idx < len) begin
                        r_idx  <= r_idx + LEN_W'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            if (r_future > {4'd0, i_cfg.ceiling, 7'd0}) begin
                                r_rem   <= SAMPLE_W'({i_cfg.ceiling, 6'd0});
                                r_req   <= '0;
                                r_cnt   <= 5'd17;
                                r_state <= B_DIV;
                            end else begin
                                r_req   <= GAIN_ONE;
                                r_state <= B_GAIN;
                            end
                        end
                    end
                end
                B_DIV: begin
                    if (trial >= {1'b0, r_future}) begin
                        r_rem <= SAMPLE_W'(trial - {1'b0, r_future});
                        r_req <= {r_req[GAIN_W-2:0], 1'b1};
                    end else begin
                        r_rem <= trial[SAMPLE_W-1:0];
                        r_req <= {r_req[GAIN_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) r_state <= B_GAIN;
                end
                B_GAIN: begin
                    r_gain  <= g_next[GAIN_W-1:0];
                    r_state <= B_SCALE;
                end
                B_SCALE: begin
                    if (out_free) begin
                        r_ol     <= r_dl[SAMPLE_W-1] ? SAMPLE_W'(-ml) : ml;
                        r_or     <= r_dr[SAMPLE_W-1] ? SAMPLE_W'(-mr) : mr;
                        r_og     <= r_gain;
                        r_ovalid <= 1'b1;
                        r_state  <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/lookahead_true_peak_limiter.sv
// Stereo lookahead limiter with 4x true-peak detection.
// Input channel: i_valid / o_stall with i_left_in, i_right_in (signed Q4.23).
// A transaction is taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_left_out, o_right_out (signed Q4.23)
// and o_gain_now (Q1.16, 65536 is unity); one result per input transaction.
// Configuration: i_cfg_valid / o_cfg_ready (always ready) with i_cfg_index and
// i_cfg_data; write only while the block is idle.
// The front unit takes a pair, estimates its true peak (one interpolation
// point per cycle while limiting is enabled) and queues it; the back unit
// reads and writes the 256-entry ring, scans the window one entry a cycle,
// runs a bit-serial divide when the peak exceeds the ceiling and scales the
// delayed pair; with limiting disabled it passes the delayed pair untouched.
// The queue lets the front accept new pairs while the back unit still works
// on earlier ones; when limiting, the window scan bounds how fast pairs pass.
// Reset clears the ring (per-entry valid bits), history and pointer and sets
// the gain to unity. On a receiver stall the result holds; the front runs on
// until the queue fills.
module lookahead_true_peak_limiter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [ltpl_pkg::SAMPLE_W-1:0] i_left_in,
    input  logic signed [ltpl_pkg::SAMPLE_W-1:0] i_right_in,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [ltpl_pkg::SAMPLE_W-1:0] o_left_out,
    output logic signed [ltpl_pkg::SAMPLE_W-1:0] o_right_out,
    output logic [ltpl_pkg::GAIN_W-1:0]          o_gain_now,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [1:0]                           i_cfg_index,
    input  logic [ltpl_pkg::RC_W-1:0]            i_cfg_data
);
    import ltpl_pkg::*;

    t_cfg  r_cfg;
    t_item push_item, head_item;
    logic  push_valid, push_ready, pop_valid, pop;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable        <= 1'b0;
            r_cfg.length        <= 9'd96;
            r_cfg.release_coeff <= 24'd4194;
            r_cfg.ceiling       <= 17'd62259;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLE:  r_cfg.enable        <= i_cfg_data[0];
                CFG_LENGTH:  r_cfg.length        <= i_cfg_data[LEN_W-1:0];
                CFG_RELEASE: r_cfg.release_coeff <= i_cfg_data;
                CFG_CEILING: r_cfg.ceiling       <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    ltpl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_enable     (r_cfg.enable),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_left       (i_left_in),
        .i_right      (i_right_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_item       (push_item)
    );

    ltpl_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push_valid),
        .o_push_ready (push_ready),
        .i_item       (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_head       (head_item)
    );

    ltpl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (pop_valid),
        .o_q_pop   (pop),
        .i_q_item  (head_item),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_left    (o_left_out),
        .o_right   (o_right_out),
        .o_gain    (o_gain_now)
    );

endmodule

FILE: tb/lookahead_true_peak_limiter_tb.sv
module lookahead_true_peak_limiter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ltpl_pkg::*;

    // Catmull-Rom weights in 1/128 at the quarter points
    localparam int CR_TAP [3][4] = '{
        '{-9, 111, 29, -3},
        '{-8, 72, 72, -8},
        '{-3, 29, 111, -9}
    };
    localparam longint unsigned PEAK_SAT = (64'd1 << SAMPLE_W) - 1;
    localparam int SETTLE_CYCLES = 400;

    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic [GAIN_W-1:0]          gain;
    } t_limited_pair;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic signed [SAMPLE_W-1:0] i_left_in;
    logic signed [SAMPLE_W-1:0] i_right_in;
    logic                       o_valid;
    logic                       i_stall;
    logic signed [SAMPLE_W-1:0] o_left_out;
    logic signed [SAMPLE_W-1:0] o_right_out;
    logic [GAIN_W-1:0]          o_gain_now;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [1:0]                 i_cfg_index;
    logic [RC_W-1:0]            i_cfg_data;

    lookahead_true_peak_limiter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_left_in   (i_left_in),
        .i_right_in  (i_right_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out),
        .o_gain_now  (o_gain_now),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the limiter state and its registers
    logic signed [SAMPLE_W-1:0] shadow_left_ring  [DEPTH];
    logic signed [SAMPLE_W-1:0] shadow_right_ring [DEPTH];
    logic [SAMPLE_W-1:0]        shadow_peak_ring  [DEPTH];
    longint                     left_hist  [3];
    longint                     right_hist [3];
    int unsigned                ring_slot;
    longint unsigned            shadow_gain;
    logic                       cfg_enable;
    logic [LEN_W-1:0]           cfg_length;
    logic [RC_W-1:0]            cfg_release;
    logic [GAIN_W-1:0]          cfg_ceiling;

    t_limited_pair expected_pairs[$];
    int            mismatches;
    int            hold_cycles;
    bit            tx_idle_on;
    bit            rx_idle_on;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Largest of the two middle history points and the three quarter points
    function automatic longint unsigned quarter_point_peak(input longint h0, input longint h1,
                                                          input longint h2, input longint x);
        longint          pts [4];
        longint          acc;
        longint unsigned pk;
        longint unsigned m;
        pts[0] = h0; pts[1] = h1; pts[2] = h2; pts[3] = x;
        pk = magnitude(h1);
        for (int k = 0; k < 3; k++) begin
            acc = 0;
            for (int j = 0; j < 4; j++) acc += CR_TAP[k][j] * pts[j];
            m = (magnitude(acc) + 64) >> 7;
            if (m > pk) pk = m;
        end
        if (magnitude(h2) > pk) pk = magnitude(h2);
        if (pk > PEAK_SAT) pk = PEAK_SAT;
        return pk;
    endfunction

    // Symmetric round-half-up scaling of a delayed sample by a Q1.16 gain
    function automatic logic signed [SAMPLE_W-1:0] apply_gain(input longint v,
                                                              input longint unsigned g);
        longint unsigned m;
        m = (magnitude(v) * g + 32768) >> 16;
        return (v < 0) ? SAMPLE_W'(-longint'(m)) : SAMPLE_W'(m);
    endfunction

    function automatic t_limited_pair limit_pair(input logic signed [SAMPLE_W-1:0] l,
                                                 input logic signed [SAMPLE_W-1:0] r);
        t_limited_pair   res;
        int unsigned     len;
        int unsigned     slot;
        longint          dl;
        longint          dr;
        longint unsigned dp;
        longint unsigned cur;
        longint unsigned t;
        longint unsigned future;
        longint unsigned required;
        longint unsigned step;
        len = cfg_length;
        if (len < LEN_MIN) len = LEN_MIN;
        if (len > LEN_MAX) len = LEN_MAX;
        slot = (ring_slot < DEPTH) ? ring_slot : 0;
        dl = shadow_left_ring[slot];
        dr = shadow_right_ring[slot];
        dp = shadow_peak_ring[slot];

        cur = magnitude(l);
        if (magnitude(r) > cur) cur = magnitude(r);
        if (cfg_enable) begin
            t = quarter_point_peak(left_hist[0], left_hist[1], left_hist[2], l);
            if (t > cur) cur = t;
            t = quarter_point_peak(right_hist[0], right_hist[1], right_hist[2], r);
            if (t > cur) cur = t;
            // advance the history only while limiting
            left_hist[0]  = left_hist[1];  left_hist[1]  = left_hist[2];  left_hist[2]  = l;
            right_hist[0] = right_hist[1]; right_hist[1] = right_hist[2]; right_hist[2] = r;
        end
        if (cur > PEAK_SAT) cur = PEAK_SAT;

        shadow_left_ring[slot]  = l;
        shadow_right_ring[slot] = r;
        shadow_peak_ring[slot]  = SAMPLE_W'(cur);
        slot++;
        if (slot >= len) slot = 0;
        ring_slot = slot;

        if (!cfg_enable) begin
            shadow_gain = GAIN_ONE;
            res.left  = SAMPLE_W'(dl);
            res.right = SAMPLE_W'(dr);
            res.gain  = GAIN_ONE;
            return res;
        end

        // the window covers slots 0..len-1 plus the slot just read
        future = dp;
        for (int i = 0; i < int'(len); i++)
            if (shadow_peak_ring[i] > future) future = shadow_peak_ring[i];

        required = GAIN_ONE;
        if (future > (longint'(cfg_ceiling) << 7))
            required = (longint'(cfg_ceiling) << 23) / future;

        if (required < shadow_gain) begin
            shadow_gain = required;
        end else begin
            step = ((GAIN_ONE - shadow_gain) * cfg_release + 64'hFFFFFF) >> 24;
            shadow_gain += step;
        end
        if (shadow_gain < GAIN_FLOOR) shadow_gain = GAIN_FLOOR;
        if (shadow_gain > GAIN_ONE) shadow_gain = GAIN_ONE;

        res.left  = apply_gain(dl, shadow_gain);
        res.right = apply_gain(dr, shadow_gain);
        res.gain  = GAIN_W'(shadow_gain);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Offer one pair, optionally after a random gap, and log the prediction on acceptance
    task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
                             input logic signed [SAMPLE_W-1:0] r);
        if (tx_idle_on && $urandom_range(99) < 6) begin
            repeat ($urandom_range(8, 1)) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid    <= 1'b1;
        i_left_in  <= l;
        i_right_in <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_pairs.push_back(limit_pair(l, r));
    endtask

    // Drop valid and wait until every pending result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_pairs.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [RC_W-1:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ENABLE:  cfg_enable  = data[0];
            CFG_LENGTH:  cfg_length  = data[LEN_W-1:0];
            CFG_RELEASE: cfg_release = data[RC_W-1:0];
            CFG_CEILING: cfg_ceiling = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    // Full-range noise now and then, otherwise noise at a random level (shift by 4 to 12)
    function automatic logic signed [SAMPLE_W-1:0] audio_sample();
        logic [31:0] raw;
        raw = $urandom;
        if ($urandom_range(9) == 0) return SAMPLE_W'(raw);
        return SAMPLE_W'($signed(raw) >>> $urandom_range(12, 4));
    endfunction

    // Receiver: check each result and choose the stall for the next cycle
    always @(posedge i_clk) begin
        t_limited_pair want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_pairs.size() == 0) begin
                report_mismatch("unexpected result, left", o_left_out, 0);
            end else begin
                want = expected_pairs.pop_front();
                if (o_left_out !== want.left)
                    report_mismatch("left_out", o_left_out, want.left);
                if (o_right_out !== want.right)
                    report_mismatch("right_out", o_right_out, want.right);
                if (o_gain_now !== want.gain)
                    report_mismatch("gain_now", o_gain_now, want.gain);
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= rx_idle_on && ($urandom_range(99) < 6);
        end
    end

    task automatic test_passthrough();
        write_register(CFG_ENABLE, '0);
        write_register(CFG_LENGTH, 9'd32);
        send_pair(28'sh7FFFFFF, 28'sh8000000);
        send_pair(28'sh8000000, 28'sh7FFFFFF);
        send_pair('0, 28'sh0800000);
        send_pair(-28'sh0800000, -28'sd1);
        send_pair(28'sd1, '0);
    endtask

    task automatic test_limiting();
        write_register(CFG_ENABLE, 24'd1);
        write_register(CFG_CEILING, 24'd65536);
        write_register(CFG_RELEASE, 24'hFFFFFF);
        // alternating-sign samples, left at unity and right at the extremes of the range
        for (int i = 0; i < 6; i++)
            send_pair((i % 2) ? 28'sh0800000 : -28'sh0800000,
                      (i % 2) ? 28'sh8000000 : 28'sh7FFFFFF);
        send_pair('0, '0);
        send_pair(28'sh7FFFFFF, 28'sh7FFFFFF);
    endtask

    task automatic test_zero_ceiling();
        write_register(CFG_CEILING, '0);
        send_pair(28'sd1, -28'sd1);
        send_pair(28'sh0400000, '0);
        write_register(CFG_RELEASE, '0);
        send_pair('0, 28'sh0100000);
    endtask

    task automatic test_length_clamp();
        write_register(CFG_CEILING, 24'd62259);
        write_register(CFG_LENGTH, '0);
        send_pair(28'sh0600000, 28'sh0900000);
        send_pair(-28'sh0900000, 28'sh0200000);
        write_register(CFG_LENGTH, 24'hFFFFFF);
        send_pair(28'sh0A00000, -28'sh0A00000);
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 6; ph++) begin
            // one phase runs with no idling at all
            tx_idle_on = (ph != 2);
            rx_idle_on = (ph != 2);
            write_register(CFG_ENABLE, (ph == 4) ? 24'd0 : 24'($urandom_range(3) != 0));
            case (ph)
                0: write_register(CFG_LENGTH, 24'd32);
                1: write_register(CFG_LENGTH, 24'd256);
                default: write_register(CFG_LENGTH, 24'($urandom));
            endcase
            write_register(CFG_RELEASE, (ph == 1) ? '0 : (ph == 3) ? 24'hFFFFFF : 24'($urandom));
            write_register(CFG_CEILING, (ph == 0) ? 24'd1 : (ph == 5) ? 24'd65536 : 24'($urandom));
            for (int i = 0; i < 85; i++) begin
                // set the window length mid-stream once, and switch limiting off and back on
                if (ph == 3 && i == 40) write_register(CFG_LENGTH, 24'd40);
                if (ph == 5 && i == 40) write_register(CFG_ENABLE, 24'd0);
                if (ph == 5 && i == 60) write_register(CFG_ENABLE, 24'd1);
                send_pair(audio_sample(), audio_sample());
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        write_register(CFG_ENABLE, 24'd1);
        write_register(CFG_LENGTH, 24'd32);
        // hold the output off long enough for the block to fill and stall its input
        hold_cycles = 3000;
        for (int i = 0; i < 30; i++) send_pair(audio_sample(), audio_sample());
        drain_results();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_left_in   <= '0;
        i_right_in  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_ENABLE;
        i_cfg_data  <= '0;
        mismatches  = 0;
        hold_cycles = 0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        for (int i = 0; i < DEPTH; i++) begin
            shadow_left_ring[i]  = '0;
            shadow_right_ring[i] = '0;
            shadow_peak_ring[i]  = '0;
        end
        for (int i = 0; i < 3; i++) begin
            left_hist[i]  = 0;
            right_hist[i] = 0;
        end
        ring_slot   = 0;
        shadow_gain = GAIN_ONE;
        cfg_enable  = 1'b0;
        cfg_length  = 9'd96;
        cfg_release = 24'd4194;
        cfg_ceiling = 17'd62259;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_passthrough();
        test_limiting();
        test_zero_ceiling();
        test_length_clamp();
        test_random_phases();
        test_backpressure();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_pairs.size() != 0)
            report_mismatch("results left over", expected_pairs.size(), 0);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

FILE: lookahead_true_peak_limiter.f
rtl/ltpl_pkg.sv
rtl/ltpl_front.sv
rtl/ltpl_queue.sv
rtl/ltpl_back.sv
rtl/lookahead_true_peak_limiter.sv
tb/lookahead_true_peak_limiter_tb.sv
